// ----- hw/rtl/led_pixel_frame_encoder_defines.svh -----
// assertion macros shared by the led pixel frame encoder rtl
// no dependencies; included by files that carry assertions
`ifndef LED_PIXEL_FRAME_ENCODER_DEFINES_SVH
`define LED_PIXEL_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every clock edge outside reset
`define LPFE_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// cond must never be seen outside reset
`define LPFE_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define LPFE_ASSERT(name, clk, rst_n, prop, msg)
`define LPFE_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/lpfe_pkg.sv -----
// shared types, constants and functions for the led pixel frame encoder
// no dependencies
`timescale 1ns / 1ps

package lpfe_pkg;

	localparam int DEF_MAX_PIXELS = 65536;
	localparam int WIN_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int COLOR_W        = 8;
	localparam int QUEUE_DEPTH    = 2;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_FIRST      = 2'd0,
		REG_WINDOW_LAST       = 2'd1,
		REG_WINDOW_OPEN_ENDED = 2'd2
	} cfg_reg_e;

	// tuser codes on the input side
	localparam logic ACT_FRAME_START = 1'b0;
	localparam logic ACT_PIXEL       = 1'b1;

	// byte positions inside one four-byte run
	localparam logic [1:0] BEAT_FLAG  = 2'd0;
	localparam logic [1:0] BEAT_BLUE  = 2'd1;
	localparam logic [1:0] BEAT_GREEN = 2'd2;
	localparam logic [1:0] BEAT_RED   = 2'd3;
	localparam logic [1:0] BEAT_LAST  = BEAT_RED;

	localparam logic [1:0] FLAG_TOP = 2'b11;

	typedef struct packed {
		logic               is_pixel;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} q_stat_t;

	// 11, then inverted top bits of blue, green, red
	function automatic logic [7:0] flag_byte(input logic [COLOR_W-1:0] red,
			input logic [COLOR_W-1:0] green, input logic [COLOR_W-1:0] blue);
		flag_byte = {FLAG_TOP, ~blue[7:6], ~green[7:6], ~red[7:6]};
	endfunction

endpackage

// ----- hw/rtl/lpfe_front.sv -----
// front end: config registers, pixel index, window check, queue push
// depends on lpfe_pkg
`timescale 1ns / 1ps

module lpfe_front import lpfe_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // red, green, blue
	input  logic                 s_axis_tuser,  // action
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIN_W-1:0]     cfg_data,
	input  q_stat_t              q_stat,
	output logic                 q_push,
	output cmd_t                 q_cmd
);

	localparam int IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PIXELS - 1);

	logic [WIN_W-1:0] window_first_q;
	logic [WIN_W-1:0] window_last_q;
	logic             window_open_ended_q;
	logic [IDX_W-1:0] pixel_index_q;
	logic [WIN_W-1:0] idx_ext;
	logic             in_window;
	logic             accept;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !q_stat.full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign idx_ext   = WIN_W'(pixel_index_q);
	assign in_window = (idx_ext >= window_first_q) &&
		(window_open_ended_q || (idx_ext <= window_last_q));

	// out-of-window pixels are dropped here, only the index moves
	assign q_push = accept && ((s_axis_tuser == ACT_FRAME_START) || in_window);

	assign q_cmd.is_pixel = (s_axis_tuser == ACT_PIXEL);
	assign q_cmd.red      = s_axis_tdata[7:0];
	assign q_cmd.green    = s_axis_tdata[15:8];
	assign q_cmd.blue     = s_axis_tdata[23:16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_first_q      <= '0;
			window_last_q       <= '1;
			window_open_ended_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WINDOW_FIRST:      window_first_q      <= cfg_data;
				REG_WINDOW_LAST:       window_last_q       <= cfg_data;
				REG_WINDOW_OPEN_ENDED: window_open_ended_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_index_q <= '0;
		end else if (accept) begin
			if (s_axis_tuser == ACT_FRAME_START) begin
				pixel_index_q <= '0;
			end else if (pixel_index_q != IDX_MAX) begin
				pixel_index_q <= pixel_index_q + 1'b1;
			end
		end
	end

endmodule

// ----- hw/rtl/lpfe_queue.sv -----
// short command queue between front and back end
// depends on lpfe_pkg and the assertion macros header
`timescale 1ns / 1ps
`include "led_pixel_frame_encoder_defines.svh"

module lpfe_queue import lpfe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	input  logic    pop,
	output cmd_t    head,
	output q_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_END = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head           = mem_q[rd_ptr_q];
	assign stat.full      = (count_q == CNT_FULL);
	assign stat.not_empty = (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_END) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_END) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`LPFE_ASSERT_NEVER(a_no_overflow, clk, arst_n, push && stat.full, "push into full queue")
	`LPFE_ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && !stat.not_empty, "pop from empty queue")
	`LPFE_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_FULL, "queue count beyond depth")
	`LPFE_ASSERT(a_count_track, clk, arst_n, (push && !pop) |=> (count_q == $past(count_q) + 1'b1), "queue count missed a push")

endmodule

// ----- hw/rtl/lpfe_back.sv -----
// back end: serializes each queued command into four output beats
// depends on lpfe_pkg
`timescale 1ns / 1ps

module lpfe_back import lpfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  q_stat_t    q_stat,
	output logic       q_pop,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // out_byte
	output logic       m_axis_tlast   // run_last
);

	logic [1:0] beat_q;
	logic       m_valid_q;
	logic [7:0] m_data_q;
	logic       m_last_q;
	logic       adv;
	logic       emit;
	logic [7:0] byte_sel;

	assign adv   = !m_valid_q || m_axis_tready;
	assign emit  = adv && q_stat.not_empty;
	// head stays in the queue until its last byte leaves
	assign q_pop = emit && (beat_q == BEAT_LAST);

	always_comb begin
		byte_sel = '0;
		if (head.is_pixel) begin
			case (beat_q)
				BEAT_FLAG:  byte_sel = flag_byte(head.red, head.green, head.blue);
				BEAT_BLUE:  byte_sel = head.blue;
				BEAT_GREEN: byte_sel = head.green;
				BEAT_RED:   byte_sel = head.red;
				default:    byte_sel = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			beat_q    <= BEAT_FLAG;
		end else begin
			if (adv) begin
				m_valid_q <= q_stat.not_empty;
			end
			if (emit) begin
				beat_q <= beat_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_data_q <= byte_sel;
			m_last_q <= (beat_q == BEAT_LAST);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

// ----- hw/rtl/led_pixel_frame_encoder.sv -----
// Encodes frame-start and RGB pixel beats into the byte stream for a chain of
// LED driver chips. Every frame start and every pixel inside the configured
// window gives four output beats (tlast on the fourth), so the sustained rate
// is set by the byte-wide output register.
// Pixels outside the window give no beat and are taken one per cycle while
// the two-entry command queue has room. No start-up pass after reset; config
// writes are always ready and take effect on the next beat.
// depends on lpfe_pkg, lpfe_front, lpfe_queue, lpfe_back
`timescale 1ns / 1ps

module led_pixel_frame_encoder import lpfe_pkg::*; #(
	parameter int MAX_PIXELS = DEF_MAX_PIXELS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,  // red, green, blue
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [7:0]           m_axis_tdata,  // out_byte
	output logic                 m_axis_tlast,  // run_last
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIN_W-1:0]     cfg_data
);

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	cmd_t    q_cmd;
	cmd_t    q_head;

	lpfe_front #(
		.MAX_PIXELS(MAX_PIXELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_stat        (q_stat),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	lpfe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.stat     (q_stat)
	);

	lpfe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_head),
		.q_stat        (q_stat),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

// ----- bench/tb.sv -----
// self-checking bench for led_pixel_frame_encoder: random frames, windows and stalls
// depends on lpfe_pkg and the encoder rtl; expected bytes come from a scoreboard class
`timescale 1ns / 1ps

module tb;
	import lpfe_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped, must be ignored
	localparam int HOLD_CYCLES = 120;
	localparam int SETTLE_CYCLES = 24;
	localparam int ITEM_TARGET = 380;
	localparam logic [WIN_W-1:0] IDX_TOP = '1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} led_byte_t;

	// mirrors the window registers and pixel counter, queues the bytes they imply
	class led_stream_board;
		logic [WIN_W-1:0] first_px;
		logic [WIN_W-1:0] last_px;
		logic             open_end;
		logic [WIN_W-1:0] px_index;
		led_byte_t        due_bytes[$];
		int unsigned      faults;

		function new();
			first_px = '0;
			last_px = '1;
			open_end = 1'b1;
			px_index = '0;
			faults = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] value);
			case (idx)
				REG_WINDOW_FIRST: first_px = value;
				REG_WINDOW_LAST: last_px = value;
				REG_WINDOW_OPEN_ENDED: open_end = value[0];
				default: ;
			endcase
		endfunction

		function void queue_byte(logic [7:0] value, logic run_last);
			due_bytes.push_back({value, run_last});
		endfunction

		// returns the number of bytes this beat should produce
		function int take_item(logic act, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
				logic [COLOR_W-1:0] b);
			logic hit;
			if (act == ACT_FRAME_START) begin
				px_index = '0;
				queue_byte(8'h00, 1'b0);
				queue_byte(8'h00, 1'b0);
				queue_byte(8'h00, 1'b0);
				queue_byte(8'h00, 1'b1);
				return 4;
			end
			hit = (px_index >= first_px) && (open_end || px_index <= last_px);
			// counter sticks at the top index
			if (px_index != IDX_TOP)
				px_index = px_index + 1'b1;
			if (!hit)
				return 0;
			queue_byte({FLAG_TOP, ~b[7:6], ~g[7:6], ~r[7:6]}, 1'b0);
			queue_byte(b, 1'b0);
			queue_byte(g, 1'b0);
			queue_byte(r, 1'b1);
			return 4;
		endfunction

		function void fault(string msg);
			faults++;
			if (faults <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_byte(logic [7:0] got_byte, logic got_last);
			led_byte_t want;
			if (due_bytes.size() == 0) begin
				fault($sformatf("unexpected byte %02h last %0b", got_byte, got_last));
				return;
			end
			want = due_bytes.pop_front();
			if (got_byte !== want.out_byte)
				fault($sformatf("out_byte expected %02h got %02h", want.out_byte, got_byte));
			if (got_last !== want.run_last)
				fault($sformatf("run_last expected %0b got %0b", want.run_last, got_last));
		endfunction

		function int pending();
			return due_bytes.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata = '0;  // red, green, blue
	logic                 s_axis_tuser = 1'b0;  // action
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [7:0]           m_axis_tdata;  // out_byte
	logic                 m_axis_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [WIN_W-1:0]     cfg_data = '0;

	led_stream_board board;
	int          idle_pct = 0;
	logic        hold_req = 1'b0;
	int unsigned sent_items = 0;

	led_pixel_frame_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	initial begin
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_byte(m_axis_tdata, m_axis_tlast);
	end

	// output side: random stall bursts plus one long hold-off on request
	initial begin : sink
		int stall;
		bit hold_done;
		stall = 0;
		hold_done = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
			end else begin
				if (stall == 0 && idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
					stall = $urandom_range(1, 11);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					stall--;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end
		end
	end

	function automatic logic [7:0] any_color();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// leaves tvalid high so back-to-back beats need no extra edge
	task automatic drive_item(input logic act, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {b, g, r};
		do @(posedge clk); while (!s_axis_tready);
		void'(board.take_item(act, r, g, b));
		sent_items++;
	endtask

	task automatic send(input logic act, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		drive_item(act, r, g, b);
	endtask

	task automatic send_rand(input logic act);
		send(act, any_color(), any_color(), any_color());
	endtask

	task automatic drain_outputs();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		// give any stray beat time to show up
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WIN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, value);
	endtask

	task automatic configure(input logic [WIN_W-1:0] first, input logic [WIN_W-1:0] last,
			input logic open_end, input bit spare);
		drain_outputs();
		cfg_write(REG_WINDOW_FIRST, first);
		cfg_write(REG_WINDOW_LAST, last);
		cfg_write(REG_WINDOW_OPEN_ENDED, {15'($urandom_range(0, 32767)), open_end});
		if (spare)
			cfg_write(REG_SPARE, 16'($urandom_range(0, 65535)));
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frames(input int frames);
		int npx;
		repeat (frames) begin
			// now and then a frame without its start beat
			if ($urandom_range(0, 9) != 0)
				send_rand(ACT_FRAME_START);
			npx = $urandom_range(0, 20);
			repeat (npx)
				send_rand(ACT_PIXEL);
		end
	endtask

	initial begin : stimulus
		int phase;
		board = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window: everything open
		idle_pct <= 20;
		send(ACT_FRAME_START, 8'hff, 8'hff, 8'hff);
		send(ACT_PIXEL, 8'h00, 8'h00, 8'h00);
		send(ACT_PIXEL, 8'hff, 8'hff, 8'hff);
		send(ACT_PIXEL, 8'hc0, 8'h40, 8'h80);
		send(ACT_PIXEL, 8'h3f, 8'h80, 8'hff);
		send_rand(ACT_PIXEL);
		send(ACT_FRAME_START, 8'h5a, 8'ha5, 8'h01);

		// bounded window 2..4, plus a write to the unmapped register
		configure(16'd2, 16'd4, 1'b0, 1);
		send_rand(ACT_FRAME_START);
		repeat (7) send_rand(ACT_PIXEL);

		// empty window
		configure(16'd5, 16'd3, 1'b0, 0);
		send_rand(ACT_FRAME_START);
		repeat (4) send_rand(ACT_PIXEL);

		// single pixel window at zero
		configure(16'd0, 16'd0, 1'b0, 0);
		send_rand(ACT_FRAME_START);
		repeat (2) send_rand(ACT_PIXEL);

		// open ended: last below first has no effect
		configure(16'd3, 16'd1, 1'b1, 0);
		send_rand(ACT_FRAME_START);
		repeat (5) send_rand(ACT_PIXEL);

		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			case ($urandom_range(0, 3))
				0: idle_pct <= 0;
				1: idle_pct <= 10;
				2: idle_pct <= 25;
				default: idle_pct <= 40;
			endcase
			case ($urandom_range(0, 9))
				0: configure(16'd0, IDX_TOP, 1'b1, $urandom_range(0, 3) == 0);
				1: configure(16'd0, 16'd0, 1'b0, $urandom_range(0, 3) == 0);
				2: configure(IDX_TOP, IDX_TOP, 1'b0, $urandom_range(0, 3) == 0);
				3: configure(IDX_TOP, 16'd0, 1'b1, $urandom_range(0, 3) == 0);
				4: configure(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
						1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
				default: configure(16'($urandom_range(0, 12)), 16'($urandom_range(0, 16)),
						1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
			endcase
			if (phase == 2) begin
				// receiver holds off while frame starts keep coming, input must back up
				hold_req <= 1'b1;
				repeat (14)
					drive_item(ACT_FRAME_START, any_color(), any_color(), any_color());
			end
			random_frames($urandom_range(2, 6));
			phase++;
		end

		// closing stretch with no idling on either side
		idle_pct <= 0;
		configure(16'd0, IDX_TOP, 1'b1, 0);
		random_frames(2);
		repeat (12)
			send_rand(ACT_PIXEL);

		drain_outputs();
		if (board.faults == 0 && board.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/lpfe_pkg.sv
hw/rtl/lpfe_front.sv
hw/rtl/lpfe_queue.sv
hw/rtl/lpfe_back.sv
hw/rtl/led_pixel_frame_encoder.sv
bench/tb.sv
